// ----- design/memory_request_indexed_queue_top_macros.svh -----
// Assertion macros shared by the request queue design files.
`ifndef MEMORY_REQUEST_INDEXED_QUEUE_TOP_MACROS_SVH
`define MEMORY_REQUEST_INDEXED_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MRIQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("request queue assertion failed");
// Next-cycle implication, disabled during reset.
`define MRIQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("request queue assertion failed");
`else
`define MRIQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MRIQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/mriq_pkg.sv -----
// Types and constants shared by the request queue cells and control.
package mriq_pkg;

  // Fixed widths of the position input and the index/count output.
  localparam int POS_W = 5;
  localparam int WOC_W = 5;

  // Operation codes.
  localparam logic [3:0] OP_INS_AT    = 4'd0;
  localparam logic [3:0] OP_INS_HEAD  = 4'd1;
  localparam logic [3:0] OP_INS_TAIL  = 4'd2;
  localparam logic [3:0] OP_DEL_AT    = 4'd3;
  localparam logic [3:0] OP_DEL_HEAD  = 4'd4;
  localparam logic [3:0] OP_DEL_TAIL  = 4'd5;
  localparam logic [3:0] OP_REPL_AT   = 4'd6;
  localparam logic [3:0] OP_REPL_HEAD = 4'd7;
  localparam logic [3:0] OP_REPL_TAIL = 4'd8;
  localparam logic [3:0] OP_READ_AT   = 4'd9;
  localparam logic [3:0] OP_READ_HEAD = 4'd10;
  localparam logic [3:0] OP_READ_TAIL = 4'd11;
  localparam logic [3:0] OP_SEARCH    = 4'd12;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD       = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  // One stored memory request.
  typedef struct packed {
    logic [63:0] time_stamp;
    logic [3:0]  core;
    logic [1:0]  kind;
    logic [5:0]  byte_sel;
    logic [3:0]  col_low;
    logic        channel;
    logic [2:0]  bank_grp;
    logic [1:0]  bank;
    logic [5:0]  col_high;
    logic [15:0] row;
  } req_data_t;

  // Input transaction payload.
  typedef struct packed {
    logic [3:0]       op;
    logic [POS_W-1:0] position;
    logic [63:0]      req_time;
    logic [3:0]       req_core;
    logic [1:0]       req_kind;
    logic [5:0]       req_byte_sel;
    logic [3:0]       req_col_low;
    logic             req_channel;
    logic [2:0]       req_bank_group;
    logic [1:0]       req_bank;
    logic [5:0]       req_col_high;
    logic [15:0]      req_row;
  } req_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]       status;
    logic [WOC_W-1:0] where_or_count;
    logic [63:0]      out_time;
    logic [3:0]       out_core;
    logic [1:0]       out_kind;
    logic [5:0]       out_byte_sel;
    logic [3:0]       out_col_low;
    logic             out_channel;
    logic [2:0]       out_bank_group;
    logic [1:0]       out_bank;
    logic [5:0]       out_col_high;
    logic [15:0]      out_row;
  } rsp_item_t;

  // Update applied to the row of cells.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE
  } cell_op_t;

  // Control sent from the sequencer to every cell.
  typedef struct packed {
    cell_op_t op;
    logic     scan_match;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } mriq_state_t;

endpackage

// ----- design/mriq_cell.sv -----
// One queue cell: holds an entry, shifts with its neighbors and forwards the scan result.
module mriq_cell import mriq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  cell_ctrl_t                   ctrl,
  input  logic [((($clog2(DEPTH+1)) > POS_W) ? $clog2(DEPTH+1) : POS_W)-1:0] pos,
  input  logic [$clog2(DEPTH+1)-1:0]   occ,
  input  req_data_t                    key,
  input  req_data_t                    left_entry,
  input  req_data_t                    right_entry,
  output req_data_t                    entry,
  input  logic                         carry_in_found,
  input  logic [$clog2(DEPTH)-1:0]     carry_in_idx,
  input  req_data_t                    carry_in_data,
  output logic                         carry_found,
  output logic [$clog2(DEPTH)-1:0]     carry_idx,
  output req_data_t                    carry_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [PW-1:0] MY_POS = PW'(INDEX);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  req_data_t entry_next;
  logic      hit;

  // A cell hits on a full-request match inside the queue, or on its position.
  always_comb begin
    if (ctrl.scan_match) begin
      hit = (entry == key) & (MY_POS < PW'(occ));
    end else begin
      hit = (pos == MY_POS);
    end
  end

  // The scan result moves one cell toward the head per cycle; the lowest hit wins.
  always_ff @(posedge clk) begin
    if (hit) begin
      carry_found <= 1'b1;
      carry_idx   <= MY_IDX;
      carry_data  <= entry;
    end else begin
      carry_found <= carry_in_found;
      carry_idx   <= carry_in_idx;
      carry_data  <= carry_in_data;
    end
  end

  // Entry update: open a gap on insert, collapse on delete, overwrite on replace.
  always_comb begin
    entry_next = entry;
    unique case (ctrl.op)
      CELL_HOLD: begin
        entry_next = entry;
      end
      CELL_INSERT: begin
        if (MY_POS > pos) begin
          entry_next = left_entry;
        end else if (MY_POS == pos) begin
          entry_next = key;
        end
      end
      CELL_DELETE: begin
        if (MY_POS >= pos) begin
          entry_next = right_entry;
        end
      end
      CELL_WRITE: begin
        if (MY_POS == pos) begin
          entry_next = key;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- design/memory_request_indexed_queue_top.sv -----
// Insert and replace go from idle straight to the apply step, whose result is registered.
// Delete, read and search pass through the scan state first, while the scan result travels
// one cell per cycle from the tail cell to the head. No new item is taken until the last
// is applied; a result waiting on rsp_stall holds the next item in the apply step until taken.
// Reset clears the occupancy, the sequencer and the result valid; entry contents are not
// cleared and no clearing pass runs, so items are taken from the first cycle after reset.
module memory_request_indexed_queue_top import mriq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req_item,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp_item
);

`include "memory_request_indexed_queue_top_macros.svh"

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  mriq_state_t      state, state_next;
  logic [IW-1:0]    scan_cnt;
  logic [CW-1:0]    occ;
  logic [3:0]       op_q;
  logic [PW-1:0]    pos_q;
  req_data_t        key_q;
  logic             accept;
  logic             apply_fire;
  logic [PW-1:0]    pos_eff;
  logic [PW-1:0]    occ_w;
  req_data_t        key_in;
  cell_ctrl_t       ctrl;
  logic             is_ins, is_del, is_repl, is_read, is_search;
  logic [1:0]       status_c;
  logic [CW-1:0]    occ_after;
  rsp_item_t        rsp_c;

  req_data_t        entries     [DEPTH];
  logic             found_c     [DEPTH+1];
  logic [IW-1:0]    idx_c       [DEPTH+1];
  req_data_t        data_c      [DEPTH+1];

  // Operations that need the scan result from the cells.
  function automatic logic op_scans(input logic [3:0] op);
    logic r;
    r = (op == OP_DEL_AT) || (op == OP_DEL_HEAD) || (op == OP_DEL_TAIL) ||
        (op == OP_READ_AT) || (op == OP_READ_HEAD) || (op == OP_READ_TAIL) ||
        (op == OP_SEARCH);
    return r;
  endfunction

  assign occ_w = PW'(occ);

  // Request fields of the incoming transaction.
  always_comb begin
    key_in.time_stamp = req_item.req_time;
    key_in.core       = req_item.req_core;
    key_in.kind       = req_item.req_kind;
    key_in.byte_sel   = req_item.req_byte_sel;
    key_in.col_low    = req_item.req_col_low;
    key_in.channel    = req_item.req_channel;
    key_in.bank_grp   = req_item.req_bank_group;
    key_in.bank       = req_item.req_bank;
    key_in.col_high   = req_item.req_col_high;
    key_in.row        = req_item.req_row;
  end

  // Effective position: head forms resolve to zero, tail forms against the occupancy.
  always_comb begin
    unique case (req_item.op)
      OP_INS_HEAD, OP_DEL_HEAD, OP_REPL_HEAD, OP_READ_HEAD: begin
        pos_eff = '0;
      end
      OP_INS_TAIL: begin
        pos_eff = occ_w;
      end
      OP_DEL_TAIL, OP_REPL_TAIL, OP_READ_TAIL: begin
        pos_eff = (occ == '0) ? '0 : (occ_w - PW'(1));
      end
      default: begin
        pos_eff = PW'(req_item.position);
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = op_scans(req_item.op) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == '0) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req_stall  = (state != ST_IDLE);
    accept     = (state == ST_IDLE) && req_valid;
    apply_fire = (state == ST_APPLY) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan counter counts down from DEPTH-1 so the tail cell's result reaches the head.
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_cnt <= IW'(DEPTH - 1);
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt - IW'(1);
    end
  end

  // Captured transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req_item.op;
      pos_q <= pos_eff;
      key_q <= key_in;
    end
  end

  // Operation decode and result status.
  always_comb begin
    is_ins    = (op_q == OP_INS_AT) || (op_q == OP_INS_HEAD) || (op_q == OP_INS_TAIL);
    is_del    = (op_q == OP_DEL_AT) || (op_q == OP_DEL_HEAD) || (op_q == OP_DEL_TAIL);
    is_repl   = (op_q == OP_REPL_AT) || (op_q == OP_REPL_HEAD) || (op_q == OP_REPL_TAIL);
    is_read   = (op_q == OP_READ_AT) || (op_q == OP_READ_HEAD) || (op_q == OP_READ_TAIL);
    is_search = (op_q == OP_SEARCH);

    priority if (is_ins) begin
      if (pos_q > occ_w) begin
        status_c = STATUS_BAD;
      end else if (occ == CW'(DEPTH)) begin
        status_c = STATUS_FULL;
      end else begin
        status_c = STATUS_OK;
      end
    end else if (is_del || is_repl || is_read) begin
      status_c = ((occ == '0) || (pos_q >= occ_w)) ? STATUS_BAD : STATUS_OK;
    end else if (is_search) begin
      if (occ == '0) begin
        status_c = STATUS_BAD;
      end else begin
        status_c = found_c[0] ? STATUS_OK : STATUS_NOT_FOUND;
      end
    end else begin
      status_c = STATUS_BAD;
    end
  end

  // Occupancy after the operation.
  always_comb begin
    occ_after = occ;
    if (status_c == STATUS_OK) begin
      if (is_ins) begin
        occ_after = occ + CW'(1);
      end else if (is_del) begin
        occ_after = occ - CW'(1);
      end
    end
  end

  // Cell control: scan mode follows the captured op; updates only on the apply step.
  always_comb begin
    ctrl.scan_match = is_search;
    ctrl.op         = CELL_HOLD;
    if (apply_fire && (status_c == STATUS_OK)) begin
      priority if (is_ins) begin
        ctrl.op = CELL_INSERT;
      end else if (is_del) begin
        ctrl.op = CELL_DELETE;
      end else if (is_repl) begin
        ctrl.op = CELL_WRITE;
      end else begin
        ctrl.op = CELL_HOLD;
      end
    end
  end

  // Result transaction.
  always_comb begin
    rsp_c                = '0;
    rsp_c.status         = status_c;
    rsp_c.where_or_count = WOC_W'(occ_after);
    if (is_search && (status_c == STATUS_OK)) begin
      rsp_c.where_or_count = WOC_W'(idx_c[0]);
    end
    if ((is_del || is_read) && (status_c == STATUS_OK)) begin
      rsp_c.out_time       = data_c[0].time_stamp;
      rsp_c.out_core       = data_c[0].core;
      rsp_c.out_kind       = data_c[0].kind;
      rsp_c.out_byte_sel   = data_c[0].byte_sel;
      rsp_c.out_col_low    = data_c[0].col_low;
      rsp_c.out_channel    = data_c[0].channel;
      rsp_c.out_bank_group = data_c[0].bank_grp;
      rsp_c.out_bank       = data_c[0].bank;
      rsp_c.out_col_high   = data_c[0].col_high;
      rsp_c.out_row        = data_c[0].row;
    end
  end

  // Occupancy and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (apply_fire) begin
        occ       <= occ_after;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      rsp_item <= rsp_c;
    end
  end

  // Nothing enters the scan chain behind the tail cell.
  assign found_c[DEPTH] = 1'b0;
  assign idx_c[DEPTH]   = '0;
  assign data_c[DEPTH]  = '0;

  // Row of cells, each linked to its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    req_data_t left_e, right_e;

    if (i == 0) begin : g_head
      assign left_e = entries[i];
    end else begin : g_mid_l
      assign left_e = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_mid_r
      assign right_e = entries[i+1];
    end

    mriq_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .pos            (pos_q),
      .occ            (occ),
      .key            (key_q),
      .left_entry     (left_e),
      .right_entry    (right_e),
      .entry          (entries[i]),
      .carry_in_found (found_c[i+1]),
      .carry_in_idx   (idx_c[i+1]),
      .carry_in_data  (data_c[i+1]),
      .carry_found    (found_c[i]),
      .carry_idx      (idx_c[i]),
      .carry_data     (data_c[i])
    );
  end

  // Occupancy never exceeds the queue depth.
  `MRIQ_ASSERT_IMPLIES(a_occ_bound, clk, rst, 1'b1, occ <= CW'(DEPTH))
  // A successful insert grows the queue by exactly one.
  `MRIQ_ASSERT_NEXT(a_ins_grow, clk, rst, apply_fire && is_ins && (status_c == STATUS_OK), occ == CW'($past(occ) + CW'(1)))
  // The apply step always leaves a result in the output register.
  `MRIQ_ASSERT_NEXT(a_apply_result, clk, rst, apply_fire, rsp_valid && (state == ST_IDLE))
  // The scan ends after its last counted cycle.
  `MRIQ_ASSERT_NEXT(a_scan_end, clk, rst, (state == ST_SCAN) && (scan_cnt == '0), state == ST_APPLY)

endmodule
